[sv/quality_binned_major_minor_tally_defines.svh]
// Assertion macros used by the checker of the quality tally.
// Stand-alone header: no other file is needed.
`ifndef QUALITY_BINNED_MAJOR_MINOR_TALLY_DEFINES_SVH
`define QUALITY_BINNED_MAJOR_MINOR_TALLY_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define QBT_ASSERT_IMM(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define QBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define QBT_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/qbt_pkg.sv]
// Shared types and constants of the quality-binned major/minor tally.
// No dependencies.
package qbt_pkg;

    typedef logic [1:0] t_func;
    typedef logic [3:0] t_code;

    localparam t_func FUNC_HEADER = 2'd0;
    localparam t_func FUNC_ENTRY  = 2'd1;
    localparam t_func FUNC_FINISH = 2'd2;

    // one-hot nucleotide codes of A, C, G, T
    localparam t_code ONE_HOT_OF [4] = '{4'd1, 4'd2, 4'd4, 4'd8};

    // q / 5 == (q * 205) >> 10 for every 8-bit q
    localparam logic [7:0] BIN_DIV_MUL   = 8'd205;
    localparam int         BIN_DIV_SHIFT = 10;

    typedef struct packed {
        logic [15:0] major;
        logic [15:0] minor;
    } t_pair;

endpackage

[sv/qbt_ram.sv]
// Simple dual-port bin memory: one write port, one registered read port.
// No dependencies.
module qbt_ram #(
    parameter int DEPTH = 9,
    parameter int WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/qbt_major.sv]
// Majority-base picker: first index wins ties, all zeros give A.
// Depends on qbt_pkg.
module qbt_major (
    input  logic [31:0]   i_count_a,
    input  logic [31:0]   i_count_c,
    input  logic [31:0]   i_count_g,
    input  logic [31:0]   i_count_t,
    output qbt_pkg::t_code o_code
);
    import qbt_pkg::*;

    logic        c_wins;
    logic        t_wins;
    logic        hi_wins;
    logic [31:0] lo_ct;
    logic [31:0] hi_ct;
    logic [1:0]  lo_idx;
    logic [1:0]  hi_idx;
    logic [1:0]  best_idx;

    // pairwise tree; lower pair and lower index keep ties
    always_comb begin
        c_wins   = i_count_c > i_count_a;
        lo_ct    = c_wins ? i_count_c : i_count_a;
        lo_idx   = c_wins ? 2'd1 : 2'd0;
        t_wins   = i_count_t > i_count_g;
        hi_ct    = t_wins ? i_count_t : i_count_g;
        hi_idx   = t_wins ? 2'd3 : 2'd2;
        hi_wins  = hi_ct > lo_ct;
        best_idx = hi_wins ? hi_idx : lo_idx;
    end

    assign o_code = ONE_HOT_OF[best_idx];

endmodule

[sv/quality_binned_major_minor_tally.sv]
// Quality-binned major/minor tally. A header word (func 0) picks the majority
// base from four counts and clears every bin at once through per-bin valid
// flags. An entry word (func 1) caps its quality, bins it by width five and
// adds its weight to the bin's major or minor total in a bin memory with a
// registered read port: read on accept, add and write back in the next cycle,
// with a forward of the last write so entries stream at one per cycle between
// emits, even into the same bin. A header or finish word that follows an entry
// waits for that write-back. A finish word (func 2) emits NUM_BINS result
// words in ascending bin order, each through a memory read, a load of the
// output register and a hand-off to the sink; no input word is taken during
// the emit. Func code 3 is accepted and ignored. Totals wrap at 16 bits.
// Depends on qbt_pkg, qbt_ram, qbt_major.
module quality_binned_major_minor_tally #(
    parameter int NUM_BINS = 9,
    parameter int QUAL_CAP = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  qbt_pkg::t_func      i_func,
    input  logic [31:0]         i_count_a,
    input  logic [31:0]         i_count_c,
    input  logic [31:0]         i_count_g,
    input  logic [31:0]         i_count_t,
    input  logic [3:0]          i_base_code,
    input  logic [7:0]          i_quality,
    input  logic [15:0]         i_weight,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_bin_index,
    output logic [15:0]         o_major_total,
    output logic [15:0]         o_minor_total,
    output logic                o_last_bin
);
    import qbt_pkg::*;

    localparam int              AW        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [7:0]      CAP       = 8'(QUAL_CAP);
    localparam logic [5:0]      LAST_BIN  = 6'(NUM_BINS - 1);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(NUM_BINS - 1);

    // emit sequencer
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;  // read address on the memory
    localparam logic [1:0] S_LOAD = 2'd2;  // read data into the output register
    localparam logic [1:0] S_SHOW = 2'd3;  // word offered to the sink

    logic [1:0]     r_state, n_state;
    logic [AW-1:0]  r_cnt;

    logic           in_fire;
    logic           out_fire;
    t_code          maj_code;
    t_code          r_major_code;

    // per-bin "written since last header"; unwritten bins read as zero
    logic [NUM_BINS-1:0] r_valid;

    // quality binning
    logic [7:0]     q_capped;
    logic [15:0]    q_prod;
    logic [5:0]     q_div;
    logic [5:0]     q_bin;
    logic [AW-1:0]  entry_addr;

    // write-back stage
    logic           r_s1_vld;
    logic [AW-1:0]  r_s1_bin;
    logic           r_s1_major;
    logic [15:0]    r_s1_w;
    logic           r_fwd_vld;
    logic [AW-1:0]  r_fwd_bin;
    t_pair          r_fwd_data;
    logic           fwd_hit;
    t_pair          rd_pair;
    t_pair          old_pair;
    t_pair          n_pair;

    logic [AW-1:0]  ram_raddr;
    logic [$bits(t_pair)-1:0] ram_rdata;

    // output register
    logic [3:0]     r_o_bin;
    logic [15:0]    r_o_major;
    logic [15:0]    r_o_minor;
    logic           r_o_last;

    // A header or finish must not pass an entry still in write-back.
    assign o_in_ready = (r_state == S_IDLE) && !(r_s1_vld && (i_func != FUNC_ENTRY));
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = o_out_valid && i_out_ready;

    qbt_major u_major (
        .i_count_a (i_count_a),
        .i_count_c (i_count_c),
        .i_count_g (i_count_g),
        .i_count_t (i_count_t),
        .o_code    (maj_code)
    );

    // cap, divide by five through the reciprocal, saturate at the last bin
    always_comb begin
        q_capped   = (i_quality > CAP) ? CAP : i_quality;
        q_prod     = 16'(q_capped) * 16'(BIN_DIV_MUL);
        q_div      = q_prod[BIN_DIV_SHIFT +: 6];
        q_bin      = (q_div > LAST_BIN) ? LAST_BIN : q_div;
        entry_addr = q_bin[AW-1:0];
    end

    assign ram_raddr = (r_state == S_RD) ? r_cnt : entry_addr;

    qbt_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH ($bits(t_pair))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_bin),
        .i_wdata (n_pair),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_pair = ram_rdata;

    // Read-modify-write. The memory read of this entry happened at the same
    // edge as the previous entry's write, so that write is forwarded here.
    always_comb begin
        fwd_hit = r_fwd_vld && (r_fwd_bin == r_s1_bin);
        if (fwd_hit) begin
            old_pair = r_fwd_data;
        end else if (r_valid[r_s1_bin]) begin
            old_pair = rd_pair;
        end else begin
            old_pair = '0;
        end
        n_pair = old_pair;
        if (r_s1_major) begin
            n_pair.major = old_pair.major + r_s1_w;
        end else begin
            n_pair.minor = old_pair.minor + r_s1_w;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_func == FUNC_FINISH)) begin
                    n_state = S_RD;
                end
            end
            S_RD:   n_state = S_LOAD;
            S_LOAD: n_state = S_SHOW;
            S_SHOW: begin
                if (i_out_ready) begin
                    n_state = (r_cnt == LAST_ADDR) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_s1_vld     <= 1'b0;
            r_fwd_vld    <= 1'b0;
            r_valid      <= '0;
            r_major_code <= ONE_HOT_OF[0];
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= in_fire && (i_func == FUNC_ENTRY);
            r_fwd_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_valid[r_s1_bin] <= 1'b1;
            end
            // header is only taken with write-back empty
            if (in_fire && (i_func == FUNC_HEADER)) begin
                r_valid      <= '0;
                r_major_code <= maj_code;
            end
            if (in_fire && (i_func == FUNC_FINISH)) begin
                r_cnt <= '0;
            end else if (out_fire && (r_cnt != LAST_ADDR)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_bin   <= entry_addr;
        r_s1_major <= (i_base_code == r_major_code);
        r_s1_w     <= i_weight;
        r_fwd_bin  <= r_s1_bin;
        r_fwd_data <= n_pair;
        if (r_state == S_LOAD) begin
            r_o_bin   <= 4'(r_cnt);
            r_o_major <= r_valid[r_cnt] ? rd_pair.major : 16'd0;
            r_o_minor <= r_valid[r_cnt] ? rd_pair.minor : 16'd0;
            r_o_last  <= (r_cnt == LAST_ADDR);
        end
    end

    assign o_out_valid   = (r_state == S_SHOW);
    assign o_bin_index   = r_o_bin;
    assign o_major_total = r_o_major;
    assign o_minor_total = r_o_minor;
    assign o_last_bin    = r_o_last;

endmodule

[sv/qbt_check.sv]
// Port-level checker of the quality tally, and its bind to the top level.
// Depends on quality_binned_major_minor_tally_defines.svh.
`include "quality_binned_major_minor_tally_defines.svh"

module qbt_check #(
    parameter int NUM_BINS = 9
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [3:0]          o_bin_index,
    input logic [15:0]         o_major_total,
    input logic [15:0]         o_minor_total,
    input logic                o_last_bin
);
    localparam logic [3:0] LAST_IDX = 4'(NUM_BINS - 1);

    logic        out_stall;
    logic        out_done;
    logic        last_ok;
    logic        blk_idle;
    logic [36:0] out_word;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_done  = o_out_valid && i_out_ready && o_last_bin;
    assign last_ok   = (o_last_bin == (o_bin_index == LAST_IDX));
    assign blk_idle  = !o_out_valid && o_in_ready;
    assign out_word  = {o_bin_index, o_major_total, o_minor_total, o_last_bin};

    // stalled result word holds
    `QBT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word), "word not held")
    // last flag marks exactly the top bin
    `QBT_ASSERT_IMM(a_last_idx, i_clk, i_rst_n, o_out_valid, last_ok, "last flag mismatch")
    // no input word taken during an emit
    `QBT_ASSERT_IMM(a_no_in_emit, i_clk, i_rst_n, o_out_valid, !o_in_ready, "ready while emitting")
    // after the last bin the block is free again
    `QBT_ASSERT_NXT(a_emit_done, i_clk, i_rst_n, out_done, blk_idle, "not idle after last bin")
    // reset leaves the block idle and ready
    `QBT_ASSERT_RST(a_rst_idle, i_clk, !i_rst_n, blk_idle, "not idle after reset")

endmodule

bind quality_binned_major_minor_tally qbt_check #(
    .NUM_BINS (NUM_BINS)
) u_qbt_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_bin_index   (o_bin_index),
    .o_major_total (o_major_total),
    .o_minor_total (o_minor_total),
    .o_last_bin    (o_last_bin)
);

[test/tb_quality_binned_major_minor_tally.sv]
`timescale 1ns / 1ps
// Self-checking bench for quality_binned_major_minor_tally: queue-fed input driver,
// result monitor, and an in-bench tally of per-bin major/minor totals.
// Depends on qbt_pkg and the block's RTL.
module tb_quality_binned_major_minor_tally;
    import qbt_pkg::*;

    localparam int NUM_BINS  = 9;
    localparam int QUAL_CAP  = 44;
    localparam int BIN_WIDTH = 5;
    // func code 3 is taken and dropped by the block
    localparam t_func FUNC_UNUSED = 2'd3;

    // SETTLE_CYCLES covers a trailing burst. A slow correct run (~480 words, ~45
    // finishes, 76% stalls on either side) stays well under the LIMIT cycle guard.
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT         = 200000;
    localparam int PHASE_WORDS   = 145;

    // idle / stall percentages per phase: sink-starved, source-starved, full rate
    localparam int SEND_IDLE_PCT  [3] = '{6, 76, 0};
    localparam int SINK_STALL_PCT [3] = '{76, 6, 0};

    typedef struct {
        t_func       func;
        logic [31:0] count_a, count_c, count_g, count_t;
        t_code       base_code;
        logic [7:0]  quality;
        logic [15:0] weight;
    } t_word;

    typedef struct {
        logic [3:0]  bin_index;
        logic [15:0] major_total;
        logic [15:0] minor_total;
        logic        last_bin;
    } t_bin_result;

    // ---------------------------------------------------------------- DUT ports
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    t_func       i_func       = FUNC_HEADER;
    logic [31:0] i_count_a    = '0;
    logic [31:0] i_count_c    = '0;
    logic [31:0] i_count_g    = '0;
    logic [31:0] i_count_t    = '0;
    logic [3:0]  i_base_code  = '0;
    logic [7:0]  i_quality    = '0;
    logic [15:0] i_weight     = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [3:0]  o_bin_index;
    logic [15:0] o_major_total;
    logic [15:0] o_minor_total;
    logic        o_last_bin;

    quality_binned_major_minor_tally #(
        .NUM_BINS (NUM_BINS),
        .QUAL_CAP (QUAL_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_count_a     (i_count_a),
        .i_count_c     (i_count_c),
        .i_count_g     (i_count_g),
        .i_count_t     (i_count_t),
        .i_base_code   (i_base_code),
        .i_quality     (i_quality),
        .i_weight      (i_weight),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bin_index   (o_bin_index),
        .o_major_total (o_major_total),
        .o_minor_total (o_minor_total),
        .o_last_bin    (o_last_bin)
    );

    // ---------------------------------------------------------------- bench state
    t_word       pending_words [$];   // words not yet shown to the block
    t_word       shown;               // word currently on the input port
    t_bin_result expected_bins [$];   // bin words still owed by the block

    // tally mirror: majority code and the two total arrays
    t_code       majority_code;
    logic [15:0] major_bins [NUM_BINS];
    logic [15:0] minor_bins [NUM_BINS];

    int words_queued   = 0;
    int words_taken    = 0;
    int phase_items    = 0;   // counted words of the current phase, func 3 excluded
    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int sink_stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Apply one accepted word to the tally mirror; a finish queues one word per bin.
    task automatic tally_word(input t_word w);
        logic [31:0] cts [4];
        logic [31:0] best_ct;
        int          best;
        int          bin;
        t_bin_result r;
        cts[0] = w.count_a;
        cts[1] = w.count_c;
        cts[2] = w.count_g;
        cts[3] = w.count_t;
        case (w.func)
            FUNC_HEADER: begin
                // strict greater-than: lowest index keeps a tie, all zero gives A
                best    = 0;
                best_ct = '0;
                for (int k = 0; k < 4; k++) begin
                    if (best_ct < cts[k]) begin
                        best_ct = cts[k];
                        best    = k;
                    end
                end
                majority_code = ONE_HOT_OF[best];
                for (int b = 0; b < NUM_BINS; b++) begin
                    major_bins[b] = '0;
                    minor_bins[b] = '0;
                end
            end
            FUNC_ENTRY: begin
                bin = ((w.quality > QUAL_CAP) ? QUAL_CAP : int'(w.quality)) / BIN_WIDTH;
                if (bin > NUM_BINS - 1) begin
                    bin = NUM_BINS - 1;
                end
                // ambiguity codes never match the one-hot majority code
                if (w.base_code == majority_code) begin
                    major_bins[bin] = major_bins[bin] + w.weight;
                end else begin
                    minor_bins[bin] = minor_bins[bin] + w.weight;
                end
            end
            FUNC_FINISH: begin
                // totals stay put; only a header clears them
                for (int b = 0; b < NUM_BINS; b++) begin
                    r.bin_index   = 4'(b);
                    r.major_total = major_bins[b];
                    r.minor_total = minor_bins[b];
                    r.last_bin    = (b == NUM_BINS - 1);
                    expected_bins.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- word builders
    // Every field random; callers overwrite what matters for the func.
    function automatic t_word noise_word();
        t_word w;
        w.func      = t_func'($urandom_range(0, 3));
        w.count_a   = $urandom;
        w.count_c   = $urandom;
        w.count_g   = $urandom;
        w.count_t   = $urandom;
        w.base_code = t_code'($urandom_range(0, 15));
        w.quality   = 8'($urandom_range(0, 255));
        w.weight    = 16'($urandom);
        return w;
    endfunction

    function automatic t_word header_word(input logic [31:0] a, c, g, t);
        t_word w;
        w         = noise_word();
        w.func    = FUNC_HEADER;
        w.count_a = a;
        w.count_c = c;
        w.count_g = g;
        w.count_t = t;
        return w;
    endfunction

    function automatic t_word entry_word(input t_code code, input logic [7:0] q,
                                         input logic [15:0] wt);
        t_word w;
        w           = noise_word();
        w.func      = FUNC_ENTRY;
        w.base_code = code;
        w.quality   = q;
        w.weight    = wt;
        return w;
    endfunction

    function automatic t_word finish_word();
        t_word w;
        w      = noise_word();
        w.func = FUNC_FINISH;
        return w;
    endfunction

    task automatic push_word(input t_word w);
        pending_words.push_back(w);
        words_queued++;
        if (w.func != FUNC_UNUSED) begin
            phase_items++;
        end
    endtask

    // One locus: usually header, a run of entries, finish. Some loci skip the header
    // (entries pile onto the previous totals), some get stray words mid-run.
    task automatic queue_locus();
        logic [31:0] cts [4];
        int          mode;
        int          lead;
        int          n_entries;
        int          pick;
        t_code       code;
        logic [7:0]  q;
        logic [15:0] wt;
        mode = $urandom_range(0, 99);
        lead = $urandom_range(0, 3);
        if ($urandom_range(0, 9) != 0) begin
            if (mode < 60) begin
                // one leading base, others at or below it (ties land here too)
                cts[lead] = $urandom;
                for (int k = 0; k < 4; k++) begin
                    if (k != lead) begin
                        cts[k] = $urandom_range(0, cts[lead]);
                    end
                end
            end else if (mode < 85) begin
                for (int k = 0; k < 4; k++) cts[k] = $urandom_range(0, 3);
            end else begin
                for (int k = 0; k < 4; k++) cts[k] = $urandom;
            end
            push_word(header_word(cts[0], cts[1], cts[2], cts[3]));
        end
        n_entries = $urandom_range(0, 24);
        for (int i = 0; i < n_entries; i++) begin
            if ($urandom_range(0, 99) < 6) begin
                push_word(noise_word());
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                code = ONE_HOT_OF[lead];
            end else if (pick < 80) begin
                code = ONE_HOT_OF[$urandom_range(0, 3)];
            end else begin
                code = t_code'($urandom_range(0, 15));
            end
            q  = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 50))
                                              : 8'($urandom_range(0, 255));
            wt = ($urandom_range(0, 99) < 60) ? 16'($urandom)
                                              : 16'($urandom_range(0, 20));
            push_word(entry_word(code, q, wt));
        end
        push_word(finish_word());
        if ($urandom_range(0, 9) == 0) begin
            push_word(finish_word());
        end
    endtask

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tally_word(shown);
                words_taken++;
            end
            // a new word may go up once the shown one is taken or nothing is shown
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    shown = pending_words.pop_front();
                    i_func      <= shown.func;
                    i_count_a   <= shown.count_a;
                    i_count_c   <= shown.count_c;
                    i_count_g   <= shown.count_g;
                    i_count_t   <= shown.count_t;
                    i_base_code <= shown.base_code;
                    i_quality   <= shown.quality;
                    i_weight    <= shown.weight;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_bin_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch($sformatf("bin word %0d arrived with none owed",
                                              o_bin_index));
                end else begin
                    want = expected_bins.pop_front();
                    if (o_bin_index !== want.bin_index)
                        report_mismatch($sformatf("bin_index got %0d want %0d",
                                                  o_bin_index, want.bin_index));
                    if (o_major_total !== want.major_total)
                        report_mismatch($sformatf("bin %0d major_total got %h want %h",
                                        want.bin_index, o_major_total, want.major_total));
                    if (o_minor_total !== want.minor_total)
                        report_mismatch($sformatf("bin %0d minor_total got %h want %h",
                                        want.bin_index, o_minor_total, want.minor_total));
                    if (o_last_bin !== want.last_bin)
                        report_mismatch($sformatf("bin %0d last_bin got %b want %b",
                                        want.bin_index, o_last_bin, want.last_bin));
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        t_word odd;
        majority_code = ONE_HOT_OF[0];
        for (int b = 0; b < NUM_BINS; b++) begin
            major_bins[b] = '0;
            minor_bins[b] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            sink_stall_pct = SINK_STALL_PCT[phase];
            if (phase == 0) begin
                // totals straight out of reset
                push_word(finish_word());
                // entries with no header yet: majority is A
                push_word(entry_word(4'd1, 8'd0, 16'hFFFF));
                push_word(entry_word(4'd1, 8'd0, 16'd1));      // wraps bin 0 to zero
                push_word(entry_word(4'd2, 8'd255, 16'hFFFF)); // quality capped, last bin
                push_word(entry_word(4'd0, 8'd44, 16'd7));     // code zero counts minor
                push_word(entry_word(4'd15, 8'd45, 16'd3));    // ambiguity code
                push_word(entry_word(4'd1, 8'd4, 16'd0));      // edge of bin 0
                push_word(entry_word(4'd1, 8'd5, 16'd9));      // first of bin 1
                odd           = finish_word();
                odd.func      = FUNC_UNUSED;                   // dropped by the block
                odd.count_a   = '1;
                odd.count_c   = '1;
                odd.count_g   = '1;
                odd.count_t   = '1;
                odd.base_code = '1;
                odd.quality   = '1;
                odd.weight    = '1;
                push_word(odd);
                push_word(finish_word());
                push_word(finish_word());                       // repeat gives same totals
                push_word(header_word('0, '0, '0, '0));         // all zero picks A
                push_word(entry_word(4'd2, 8'd40, 16'd100));
                push_word(finish_word());
                push_word(header_word('1, '1, '1, '1));         // full tie picks A
                push_word(header_word('0, '1, '0, '0));         // C leads
                push_word(entry_word(4'd2, 8'd39, 16'd5));
                push_word(entry_word(4'd3, 8'd10, 16'd6));
                push_word(finish_word());
                push_word(header_word(32'd5, 32'd5, 32'd6, 32'd6)); // G over T on tie
                push_word(entry_word(4'd4, 8'd20, 16'hFFFF));
                push_word(header_word(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, '1));
                push_word(entry_word(4'd8, 8'd255, 16'h8000));
                push_word(entry_word(4'd8, 8'd200, 16'h8000));  // wraps in last bin
                push_word(finish_word());
            end
            phase_items = 0;
            while (phase_items < PHASE_WORDS) queue_locus();
            while (pending_words.size() != 0) @(negedge i_clk);
        end

        while (words_taken != words_queued || expected_bins.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("quality_binned_major_minor_tally test passed");
        end else begin
            $display("quality_binned_major_minor_tally test failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        while (cycle_count < LIMIT) @(posedge i_clk);
        $display("quality_binned_major_minor_tally test failed");
        $finish;
    end

endmodule
